FILE: hdl/cc20_pkg.sv
// Shared constants, types and quarter-round helpers for the ChaCha20 stream cipher.
package cc20_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned NUM_WORDS = 16;
  localparam int unsigned BLK_BYTES = 64;
  localparam int unsigned BLK_W    = WORD_W * NUM_WORDS;
  localparam int unsigned NUM_ROUNDS = 20;
  localparam int unsigned RND_W    = $clog2(NUM_ROUNDS);
  localparam int unsigned POS_W    = $clog2(BLK_BYTES);

  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 3;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_KEY0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE0 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE1 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CTR    = 3'd6;

  // "expand 32-byte k"
  localparam logic [WORD_W-1:0] SIGMA0 = 32'h6170_7865;
  localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320_646e;
  localparam logic [WORD_W-1:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [WORD_W-1:0] SIGMA3 = 32'h6b20_6574;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic       load;     // copy initial state into the working words
    logic       round;    // apply one quarter-round step on all four lanes
    logic       diag;     // diagonal round when set, column round otherwise
    logic [1:0] step;     // which of the four quarter-round steps
    logic       finish;   // add initial state, move result to keystream
    logic       consume;  // take one keystream byte into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } qr_words_t;

  function automatic word_t rol32(input word_t x, input int unsigned n);
    rol32 = (x << n) | (x >> (WORD_W - n));
  endfunction

  // One add / xor / rotate step of the quarter round
  function automatic qr_words_t qr_step(input qr_words_t q, input logic [1:0] step);
    qr_words_t r;
    r = q;
    unique case (step)
      2'd0: begin
        r.a = q.a + q.b;
        r.d = rol32(q.d ^ r.a, 16);
      end
      2'd1: begin
        r.c = q.c + q.d;
        r.b = rol32(q.b ^ r.c, 12);
      end
      2'd2: begin
        r.a = q.a + q.b;
        r.d = rol32(q.d ^ r.a, 8);
      end
      default: begin
        r.c = q.c + q.d;
        r.b = rol32(q.b ^ r.c, 7);
      end
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/cc20_if.sv
// Input and output stream channels of the ChaCha20 stream cipher.
interface cc20_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cc20_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_out;

  modport source (output valid, output out_byte, output last_out, input ready);
  modport sink   (input valid, input out_byte, input last_out, output ready);
endinterface

FILE: hdl/cc20_ctrl.sv
// Controller: block generation sequencing, keystream position and output handshake.
module cc20_ctrl
  import cc20_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_reload,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ctrl_cmd_t cmd
);

  localparam logic [1:0] S_EMPTY = 2'd0;
  localparam logic [1:0] S_ROUND = 2'd1;
  localparam logic [1:0] S_FINAL = 2'd2;
  localparam logic [1:0] S_FULL  = 2'd3;

  logic [1:0]       state, state_next;
  logic [RND_W-1:0] rnd, rnd_next;
  logic [1:0]       step, step_next;
  logic [POS_W-1:0] pos, pos_next;
  logic             out_free;
  logic             xfer_in;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_FULL) && out_free && !cfg_reload;
  assign xfer_in  = in_valid && in_ready;

  always_comb begin
    state_next  = state;
    rnd_next    = rnd;
    step_next   = step;
    pos_next    = pos;
    cmd         = '0;
    cmd.diag    = rnd[0];
    cmd.step    = step;
    unique case (state)
      S_EMPTY: begin
        // start a block only when a byte is waiting for it
        if (in_valid) begin
          cmd.load   = 1'b1;
          rnd_next   = '0;
          step_next  = '0;
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        step_next = step + 2'd1;
        if (step == 2'd3) begin
          rnd_next = rnd + RND_W'(1);
          if (rnd == RND_W'(NUM_ROUNDS - 1)) begin
            state_next = S_FINAL;
          end
        end
      end
      S_FINAL: begin
        cmd.finish = 1'b1;
        pos_next   = '0;
        state_next = S_FULL;
      end
      default: begin
        if (xfer_in) begin
          cmd.consume = 1'b1;
          pos_next    = pos + POS_W'(1);
          if (pos == POS_W'(BLK_BYTES - 1)) begin
            state_next = S_EMPTY;
          end
        end
      end
    endcase
    // a register write drops whatever keystream is left
    if (cfg_reload) begin
      state_next = S_EMPTY;
      cmd.load   = 1'b0;
      cmd.round  = 1'b0;
      cmd.finish = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_EMPTY;
      rnd       <= '0;
      step      <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      rnd   <= rnd_next;
      step  <= step_next;
      pos   <= pos_next;
      if (xfer_in) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/cc20_datapath.sv
// Datapath: configuration registers, block counter, four quarter-round lanes, keystream.
module cc20_datapath
  import cc20_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_reload,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  ctrl_cmd_t            cmd,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output logic [7:0]           out_byte,
  output logic                 last_out
);

  logic [CFG_W-1:0] key0, key1, key2, key3, nonce0;
  word_t            nonce1, ctr_init;
  word_t            blk_ctr;
  word_t            ctr_used;
  word_t            w      [NUM_WORDS];
  word_t            w_next [NUM_WORDS];
  word_t            init   [NUM_WORDS];
  logic [BLK_W-1:0] ks;
  logic [BLK_W-1:0] ks_sum;

  always_comb begin
    init[0]  = SIGMA0;
    init[1]  = SIGMA1;
    init[2]  = SIGMA2;
    init[3]  = SIGMA3;
    init[4]  = key0[31:0];
    init[5]  = key0[63:32];
    init[6]  = key1[31:0];
    init[7]  = key1[63:32];
    init[8]  = key2[31:0];
    init[9]  = key2[63:32];
    init[10] = key3[31:0];
    init[11] = key3[63:32];
    init[12] = ctr_used;
    init[13] = nonce0[31:0];
    init[14] = nonce0[63:32];
    init[15] = nonce1;
  end

  // Four lanes, each doing one step of its quarter round
  always_comb begin
    qr_words_t q;
    qr_words_t r;
    int unsigned ib, ic, id;
    for (int unsigned k = 0; k < NUM_WORDS; k++) begin
      w_next[k] = w[k];
    end
    for (int unsigned i = 0; i < 4; i++) begin
      if (cmd.diag) begin
        ib = 4 + ((i + 1) & 3);
        ic = 8 + ((i + 2) & 3);
        id = 12 + ((i + 3) & 3);
      end else begin
        ib = 4 + i;
        ic = 8 + i;
        id = 12 + i;
      end
      q.a = w[i];
      q.b = w[ib];
      q.c = w[ic];
      q.d = w[id];
      r = qr_step(q, cmd.step);
      w_next[i]  = r.a;
      w_next[ib] = r.b;
      w_next[ic] = r.c;
      w_next[id] = r.d;
    end
  end

  always_comb begin
    for (int unsigned k = 0; k < NUM_WORDS; k++) begin
      ks_sum[k*WORD_W +: WORD_W] = w[k] + init[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key0     <= '0;
      key1     <= '0;
      key2     <= '0;
      key3     <= '0;
      nonce0   <= '0;
      nonce1   <= '0;
      ctr_init <= '0;
      blk_ctr  <= '0;
    end else if (cfg_reload) begin
      unique case (cfg_index)
        REG_KEY0:   key0     <= cfg_data;
        REG_KEY1:   key1     <= cfg_data;
        REG_KEY2:   key2     <= cfg_data;
        REG_KEY3:   key3     <= cfg_data;
        REG_NONCE0: nonce0   <= cfg_data;
        REG_NONCE1: nonce1   <= cfg_data[31:0];
        default:    ctr_init <= cfg_data[31:0];
      endcase
      blk_ctr <= (cfg_index == REG_CTR) ? cfg_data[31:0] : ctr_init;
    end else if (cmd.load) begin
      blk_ctr <= blk_ctr + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ctr_used <= blk_ctr;
      // the counter word comes straight from the live counter
      for (int unsigned k = 0; k < NUM_WORDS; k++) begin
        w[k] <= (k == 12) ? blk_ctr : init[k];
      end
    end else if (cmd.round) begin
      for (int unsigned k = 0; k < NUM_WORDS; k++) begin
        w[k] <= w_next[k];
      end
    end
    if (cmd.finish) begin
      ks <= ks_sum;
    end else if (cmd.consume) begin
      // advance to the next keystream byte
      ks <= {8'h00, ks[BLK_W-1:8]};
    end
    if (cmd.consume) begin
      out_byte <= data_byte ^ ks[7:0];
      last_out <= last_byte;
    end
  end

endmodule

FILE: hdl/chacha20_stream_cipher_unit.sv
// ChaCha20 stream cipher: one byte in, the byte XOR keystream out, via a registered result.
// Output: a byte within a ready block shows up at the output in the cycle after its transfer;
// a byte that needs a fresh block waits for the load, the quarter-round steps and the add.
// Throughput: one byte per cycle inside a block while the output is not stalled; no byte is
// taken while the four shared lanes make the next block, one add/xor/rotate step per cycle.
// Reset (synchronous, rst high): config registers and block counter go to 0, keystream empty.
module chacha20_stream_cipher_unit
  import cc20_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  cc20_in_if.sink              in_ch,
  cc20_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic      cfg_reload;
  ctrl_cmd_t cmd;

  // indexes past the last register are dropped
  assign cfg_reload = cfg_we && (cfg_index <= REG_CTR);

  cc20_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_reload (cfg_reload),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .cmd        (cmd)
  );

  cc20_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_reload (cfg_reload),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .data_byte  (in_ch.data_byte),
    .last_byte  (in_ch.last_byte),
    .out_byte   (out_ch.out_byte),
    .last_out   (out_ch.last_out)
  );

endmodule
